// ----- hw/rtl/plb_pkg.sv -----
// Shared constants and types for the piecewise-linear branch predictor.
// Used by plb_sum, piecewise_linear_branch_predictor and the testbench; depends on nothing.
package plb_pkg;

    localparam int PC_INDEX_BITS_DEF        = 6;
    localparam int ADDRESS_HISTORY_BITS_DEF = 6;
    localparam int HISTORY_LENGTH_DEF       = 15;
    localparam int WEIGHT_BITS_DEF          = 8;

    // Reported sum and training threshold formats.
    localparam int SUM_BITS    = 13;
    localparam int SUM_MAX     = 4095;
    localparam int SUM_MIN     = -4096;
    localparam int THRESH_BITS = 12;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd54;

    // Item operation codes.
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SUM
    } plb_state_t;

endpackage

// ----- hw/rtl/plb_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module plb_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/plb_sum.sv -----
// Two-level signed adder tree for the perceptron sum, with saturation to the reported width.
// Depends on plb_pkg.
module plb_sum #(
    parameter int WEIGHT_BITS = plb_pkg::WEIGHT_BITS_DEF,
    parameter int SLOTS       = plb_pkg::HISTORY_LENGTH_DEF + 1
) (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic [SLOTS*(WEIGHT_BITS+1)-1:0]     weights,
    input  logic [SLOTS-1:0]                     add_sel,
    output logic signed [plb_pkg::SUM_BITS-1:0]  sum_sat
);

    import plb_pkg::*;

    localparam int WW      = WEIGHT_BITS + 1;
    localparam int ACC_RAW = WW + $clog2(SLOTS) + 2;
    localparam int ACC_W   = (ACC_RAW > SUM_BITS) ? ACC_RAW : SUM_BITS + 1;
    localparam int GROUPS  = (SLOTS + 3) / 4;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SUM_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SUM_MIN);

    logic signed [ACC_W-1:0] grp_next [GROUPS];
    logic signed [ACC_W-1:0] grp_reg  [GROUPS];
    logic signed [ACC_W-1:0] total;

    // First level: each group adds or subtracts up to four signed terms.
    always_comb
    begin
        logic signed [WW-1:0]    w;
        logic signed [ACC_W-1:0] term;
        int idx;
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < 4; k++)
            begin
                idx = 4 * g + k;
                if (idx < SLOTS)
                begin
                    w    = signed'(weights[idx*WW +: WW]);
                    term = ACC_W'(w);
                    grp_next[g] = add_sel[idx] ? grp_next[g] + term : grp_next[g] - term;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            total = total + grp_reg[g];
        end
        if (total > SAT_HI)
        begin
            sum_sat = SUM_BITS'(SUM_MAX);
        end
        else if (total < SAT_LO)
        begin
            sum_sat = SUM_BITS'(SUM_MIN);
        end
        else
        begin
            sum_sat = total[SUM_BITS-1:0];
        end
    end

endmodule

// ----- hw/rtl/piecewise_linear_branch_predictor.sv -----
// Piecewise-linear perceptron branch predictor top level; uses plb_pkg, plb_ram and plb_sum.
// A predict passes through the execute and sum states before its result is registered; the sum
// state waits while the previous result is still unread. An update uses the execute state only.
// One item is in work at a time; the weight bank read latency and the registered sum tree set this.
// After reset the banks are cleared one row per cycle, all 2^(PC_INDEX_BITS+ADDRESS_HISTORY_BITS)
// rows (4096 by default), with in_ready low; configuration writes are taken throughout.
module piecewise_linear_branch_predictor #(
    parameter int PC_INDEX_BITS        = plb_pkg::PC_INDEX_BITS_DEF,
    parameter int ADDRESS_HISTORY_BITS = plb_pkg::ADDRESS_HISTORY_BITS_DEF,
    parameter int HISTORY_LENGTH       = plb_pkg::HISTORY_LENGTH_DEF,
    parameter int WEIGHT_BITS          = plb_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [31:0]                         pc,
    input  logic                                taken,
    input  logic                                predicted_taken,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                prediction,
    output logic signed [plb_pkg::SUM_BITS-1:0] weight_sum,
    input  logic                                cfg_we,
    input  logic [plb_pkg::THRESH_BITS-1:0]     cfg_wdata
);

    import plb_pkg::*;

    localparam int SLOTS = HISTORY_LENGTH + 1;
    localparam int WW    = WEIGHT_BITS + 1;
    localparam int AW    = PC_INDEX_BITS + ADDRESS_HISTORY_BITS;
    localparam int DEPTH = 1 << AW;
    localparam logic signed [WW-1:0] WMAX = WW'((1 << WEIGHT_BITS) - 1);
    localparam logic signed [WW-1:0] WMIN = WW'(-((1 << WEIGHT_BITS) - 1));
    localparam logic signed [WW-1:0] ONE  = WW'(1);

    plb_state_t state_reg, state_next;

    logic [AW-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic                            op_reg;
    logic [PC_INDEX_BITS-1:0]        row_reg;
    logic [ADDRESS_HISTORY_BITS-1:0] addr_reg;
    logic                            taken_reg;
    logic                            pt_reg;
    logic [THRESH_BITS-1:0]          thresh_reg;
    logic signed [SUM_BITS-1:0]      last_sum_reg;
    logic                            out_valid_reg, out_valid_next;
    logic                            prediction_reg;
    logic signed [SUM_BITS-1:0]      weight_sum_reg;
    logic [ADDRESS_HISTORY_BITS-1:0] addr_hist_reg  [HISTORY_LENGTH];
    logic [ADDRESS_HISTORY_BITS-1:0] addr_hist_next [HISTORY_LENGTH];
    logic [HISTORY_LENGTH-1:0]       outc_hist_reg, outc_hist_next;

    logic                            clearing;
    logic                            train_we;
    logic                            grp_load;
    logic                            out_load;
    logic                            hist_shift;
    logic                            train;
    logic [SUM_BITS-1:0]             last_mag;

    logic [WW-1:0]                   bank_rdata [SLOTS];
    logic [SLOTS*WW-1:0]             weights_flat;
    logic [SLOTS-1:0]                add_sel;
    logic signed [SUM_BITS-1:0]      sum_sat;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (op_reg == OP_PREDICT) ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Training is decided from the sum kept by the last predict.
    assign last_mag = last_sum_reg[SUM_BITS-1] ? (~last_sum_reg + 1'b1) : last_sum_reg;
    assign train    = (last_mag < {1'b0, thresh_reg}) || (taken_reg != pt_reg);

    // Outputs of the state machine.
    always_comb
    begin
        in_ready   = 1'b0;
        clearing   = 1'b0;
        train_we   = 1'b0;
        grp_load   = 1'b0;
        out_load   = 1'b0;
        hist_shift = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                grp_load   = (op_reg == OP_PREDICT);
                train_we   = (op_reg == OP_UPDATE) && train;
                hist_shift = (op_reg == OP_UPDATE);
            end
            ST_SUM:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign clr_cnt_next   = clr_cnt_reg + 1'b1;
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // History shift on every update.
    always_comb
    begin
        addr_hist_next[0] = addr_reg;
        outc_hist_next[0] = taken_reg;
        for (int i = 1; i < HISTORY_LENGTH; i++)
        begin
            addr_hist_next[i] = addr_hist_reg[i-1];
            outc_hist_next[i] = outc_hist_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            thresh_reg    <= THRESH_RESET;
            last_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
            outc_hist_reg <= '0;
            for (int i = 0; i < HISTORY_LENGTH; i++)
            begin
                addr_hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_next;
            end
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                last_sum_reg <= sum_sat;
            end
            if (hist_shift)
            begin
                outc_hist_reg <= outc_hist_next;
                for (int i = 0; i < HISTORY_LENGTH; i++)
                begin
                    addr_hist_reg[i] <= addr_hist_next[i];
                end
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= operation;
            row_reg   <= pc[PC_INDEX_BITS-1:0];
            addr_reg  <= pc[ADDRESS_HISTORY_BITS-1:0];
            taken_reg <= taken;
            pt_reg    <= predicted_taken;
        end
        if (out_load)
        begin
            prediction_reg <= !sum_sat[SUM_BITS-1];
            weight_sum_reg <= sum_sat;
        end
    end

    // One bank per weight position. Bank 0 holds the bias weights, bank p+1 serves history slot p.
    // Reads are issued from the input port while idle, so data is ready in the execute cycle.
    for (genvar b = 0; b < SLOTS; b++)
    begin : g_bank
        logic [ADDRESS_HISTORY_BITS-1:0] hist_addr;
        logic                            step_up;
        logic signed [WW-1:0]            w;
        logic signed [WW-1:0]            w_new;
        logic [AW-1:0]                   raddr;
        logic [AW-1:0]                   waddr;
        logic [WW-1:0]                   wdata;

        if (b == 0)
        begin : g_bias
            assign hist_addr = '0;
            assign step_up   = taken_reg;
            assign add_sel[b] = 1'b1;
        end
        else
        begin : g_hist
            assign hist_addr  = addr_hist_reg[b-1];
            assign step_up    = (outc_hist_reg[b-1] == taken_reg);
            assign add_sel[b] = outc_hist_reg[b-1];
        end

        assign w = signed'(bank_rdata[b]);

        always_comb
        begin
            if (step_up)
            begin
                w_new = (w < WMAX) ? w + ONE : w;
            end
            else
            begin
                w_new = (w > WMIN) ? w - ONE : w;
            end
        end

        assign raddr = {pc[PC_INDEX_BITS-1:0], hist_addr};
        assign waddr = clearing ? clr_cnt_reg : {row_reg, hist_addr};
        assign wdata = clearing ? '0 : w_new;
        assign weights_flat[b*WW +: WW] = bank_rdata[b];

        plb_ram #(
            .WIDTH (WW),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (clearing || train_we),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (raddr),
            .rdata (bank_rdata[b])
        );
    end

    plb_sum #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .SLOTS       (SLOTS)
    ) u_sum (
        .clk     (clk),
        .load    (grp_load),
        .weights (weights_flat),
        .add_sel (add_sel),
        .sum_sat (sum_sat)
    );

    assign out_valid  = out_valid_reg;
    assign prediction = prediction_reg;
    assign weight_sum = weight_sum_reg;

endmodule

// ----- bench/piecewise_linear_branch_predictor_test.sv -----
// Self-checking testbench for the piecewise-linear perceptron branch predictor.
// Depends on plb_pkg and on the piecewise_linear_branch_predictor RTL; it reads no files.
module piecewise_linear_branch_predictor_test;
    import plb_pkg::*;

    localparam int ROW_BITS      = PC_INDEX_BITS_DEF;
    localparam int ADDR_BITS     = ADDRESS_HISTORY_BITS_DEF;
    localparam int HISTORY_DEPTH = HISTORY_LENGTH_DEF;
    localparam int SLOTS         = HISTORY_DEPTH + 1;
    localparam int WEIGHT_LIMIT  = (1 << WEIGHT_BITS_DEF) - 1;
    localparam int WEIGHT_COUNT  = (1 << ROW_BITS) * (1 << ADDR_BITS) * SLOTS;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;
    localparam logic [ROW_BITS-1:0] TAKEN_ROW     = 'h2A;
    localparam logic [ROW_BITS-1:0] NOT_TAKEN_ROW = 'h15;

    typedef struct packed {
        logic                       prediction;
        logic signed [SUM_BITS-1:0] sum;
    } branch_result_t;

    class perceptron_predictor;
        logic signed [WEIGHT_BITS_DEF:0] weight_mem [WEIGHT_COUNT];
        logic [ADDR_BITS-1:0]            addr_hist [HISTORY_DEPTH];
        logic [HISTORY_DEPTH-1:0]        outcome_hist;
        logic signed [SUM_BITS-1:0]      kept_sum;
        logic [THRESH_BITS-1:0]          threshold;
        logic                            last_direction;
        branch_result_t                  expected_q [$];
        int                              mismatches;

        function new();
            foreach (weight_mem[i]) weight_mem[i] = '0;
            foreach (addr_hist[i]) addr_hist[i] = '0;
            outcome_hist   = '0;
            kept_sum       = '0;
            threshold      = THRESH_RESET;
            last_direction = 1'b0;
            mismatches     = 0;
        endfunction

        function int slot(logic [ROW_BITS-1:0] row, logic [ADDR_BITS-1:0] addr, int pos);
            return (int'(row) * (1 << ADDR_BITS) + int'(addr)) * SLOTS + pos;
        endfunction

        function void train_weight(int idx, bit up);
            if (up)
            begin
                if (weight_mem[idx] < WEIGHT_LIMIT) weight_mem[idx] += 1;
            end
            else if (weight_mem[idx] > -WEIGHT_LIMIT)
            begin
                weight_mem[idx] -= 1;
            end
        endfunction

        function void accept_item(logic op, logic [31:0] addr, logic t, logic pt);
            logic [ROW_BITS-1:0] row;
            int sum;
            int mag;
            row = addr[ROW_BITS-1:0];
            if (op == OP_PREDICT)
            begin
                sum = weight_mem[slot(row, '0, 0)];
                for (int p = 0; p < HISTORY_DEPTH; p++)
                begin
                    if (outcome_hist[p]) sum += weight_mem[slot(row, addr_hist[p], p + 1)];
                    else sum -= weight_mem[slot(row, addr_hist[p], p + 1)];
                end
                if (sum > SUM_MAX) sum = SUM_MAX;
                if (sum < SUM_MIN) sum = SUM_MIN;
                kept_sum = SUM_BITS'(sum);
                last_direction = (sum >= 0);
                expected_q.push_back('{last_direction, kept_sum});
            end
            else
            begin
                mag = (kept_sum < 0) ? -int'(kept_sum) : int'(kept_sum);
                // Train on a misprediction or when the margin is too thin.
                if (mag < int'(threshold) || t != pt)
                begin
                    train_weight(slot(row, '0, 0), t);
                    for (int p = 0; p < HISTORY_DEPTH; p++)
                        train_weight(slot(row, addr_hist[p], p + 1), outcome_hist[p] == t);
                end
                for (int p = HISTORY_DEPTH - 1; p >= 1; p--)
                    addr_hist[p] = addr_hist[p - 1];
                addr_hist[0] = addr[ADDR_BITS-1:0];
                outcome_hist = {outcome_hist[HISTORY_DEPTH-2:0], t};
            end
        endfunction

        function void report(string field, longint want, longint got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_prediction(logic pred, logic signed [SUM_BITS-1:0] sum);
            branch_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: prediction %0d, weight_sum %0d", pred, sum);
                return;
            end
            want = expected_q.pop_front();
            if (pred !== want.prediction) report("prediction", want.prediction, pred);
            if (sum !== want.sum) report("weight_sum", want.sum, sum);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       operation;
    logic [31:0]                pc;
    logic                       taken;
    logic                       predicted_taken;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       prediction;
    logic signed [SUM_BITS-1:0] weight_sum;
    logic                       cfg_we;
    logic [THRESH_BITS-1:0]     cfg_wdata;

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int cycle_count  = 0;

    perceptron_predictor perceptron;

    piecewise_linear_branch_predictor dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .pc              (pc),
        .taken           (taken),
        .predicted_taken (predicted_taken),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .prediction      (prediction),
        .weight_sum      (weight_sum),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check every transfer, then pick the next cycle's ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) perceptron.check_prediction(prediction, weight_sum);
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic offer_item(logic op, logic [31:0] addr, logic t, logic pt);
        if ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        in_valid        <= 1'b1;
        operation       <= op;
        pc              <= addr;
        taken           <= t;
        predicted_taken <= pt;
        do @(posedge clk); while (!in_ready);
        perceptron.accept_item(op, addr, t, pt);
    endtask

    // Predict a branch, then resolve it with the direction the model predicted for it.
    task automatic run_branch(logic [31:0] addr, logic t);
        offer_item(OP_PREDICT, addr, 1'($urandom), 1'($urandom));
        offer_item(OP_UPDATE, addr, t, perceptron.last_direction);
    endtask

    task automatic write_threshold(logic [THRESH_BITS-1:0] value);
        in_valid <= 1'b0;
        while (perceptron.pending() != 0) @(posedge clk);
        // An update leaves no result behind, so give it time to finish.
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        perceptron.threshold = value;
    endtask

    task automatic run_traffic(int item_count);
        int          issued;
        int          roll;
        logic [31:0] addr;
        issued = 0;
        while (issued < item_count)
        begin
            roll = $urandom_range(0, 99);
            addr = $urandom();
            // Two hot branches drive their weights toward saturation.
            if (roll < 70)
            begin
                addr[ROW_BITS-1:0] = TAKEN_ROW;
                run_branch(addr, $urandom_range(0, 31) != 0);
                issued += 2;
            end
            else if (roll < 82)
            begin
                addr[ROW_BITS-1:0] = NOT_TAKEN_ROW;
                run_branch(addr, $urandom_range(0, 31) == 0);
                issued += 2;
            end
            else if (roll < 94)
            begin
                run_branch(addr, 1'($urandom));
                issued += 2;
            end
            else
            begin
                offer_item(1'($urandom), addr, 1'($urandom), 1'($urandom));
                issued += 1;
            end
        end
    endtask

    initial
    begin
        int thresholds [6];
        int settle;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        operation       = OP_PREDICT;
        pc              = '0;
        taken           = 1'b0;
        predicted_taken = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        perceptron      = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Updates before any prediction see a kept sum of zero and always train.
        offer_item(OP_UPDATE, 32'h0000_0000, 1'b1, 1'b1);
        offer_item(OP_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // Predictions ignore the outcome fields.
        offer_item(OP_PREDICT, 32'h0000_0000, 1'b1, 1'b1);
        offer_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0);
        run_branch(32'h8000_0000, 1'b1);
        run_branch(32'h7FFF_FFC0, 1'b0);
        run_branch(32'hFFFF_FFFF, 1'b1);
        offer_item(OP_UPDATE, 32'h0000_003F, 1'b1, 1'b0);
        offer_item(OP_UPDATE, 32'h5555_5555, 1'b0, 1'b1);
        for (int i = 0; i < 4; i++) run_branch(32'hAAAA_AAAA, 1'b1);

        thresholds = '{4095, 0, 4095, 4095, $urandom_range(1, 4094), 4095};
        for (int seg = 0; seg < 6; seg++)
        begin
            write_threshold(THRESH_BITS'(thresholds[seg]));
            in_idle_pct  = (seg < 2) ? 17 : (seg < 4) ? 80 : 0;
            out_idle_pct = (seg < 2) ? 80 : (seg < 4) ? 17 : 0;
            run_traffic(213);
        end
        in_valid <= 1'b0;

        settle = 0;
        while (perceptron.pending() != 0 && settle < 5000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (10) @(posedge clk);
        if (perceptron.pending() != 0)
        begin
            $display("%0d expected results never arrived", perceptron.pending());
            perceptron.mismatches += perceptron.pending();
        end
        if (perceptron.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/plb_pkg.sv
hw/rtl/plb_ram.sv
hw/rtl/plb_sum.sv
hw/rtl/piecewise_linear_branch_predictor.sv
bench/piecewise_linear_branch_predictor_test.sv
